FILE: rtl/fbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg: shared types and constants of the page framebuffer
// Screen geometry, store addressing, operation codes and the structs that
// pass between the decoder, the frame store and the top level.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int unsigned SCREEN_COLUMNS = 128;
  localparam int unsigned SCREEN_PAGES   = 4;
  localparam int unsigned STRIPE_BITS    = 8;
  localparam int unsigned PIXEL_ROWS     = SCREEN_PAGES * STRIPE_BITS;
  localparam int unsigned STORE_DEPTH    = SCREEN_COLUMNS * SCREEN_PAGES;
  localparam int unsigned ADDR_W         = $clog2(STORE_DEPTH);
  localparam int unsigned LIN_W          = 11;

  // Reciprocals for the wrap of an 8-bit coordinate by a constant.
  localparam int unsigned RECIP_SHIFT    = 16;
  localparam int unsigned RECIP_COLUMNS  = (1 << RECIP_SHIFT) / SCREEN_COLUMNS;
  localparam int unsigned RECIP_PAGES    = (1 << RECIP_SHIFT) / SCREEN_PAGES;
  localparam int unsigned RECIP_ROWS     = (1 << RECIP_SHIFT) / PIXEL_ROWS;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [7:0]        byte_t;

  typedef enum logic [1:0] {
    OP_WR_PIXEL  = 2'd0,
    OP_RD_PIXEL  = 2'd1,
    OP_WR_COLUMN = 2'd2,
    OP_RD_COLUMN = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    addr_t      addr;
    logic [2:0] bit_sel;
    byte_t      wdata;
  } access_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    byte_t data;
  } wr_port_t;

  // Remainder of v by divisor. The quotient estimate from the truncated
  // reciprocal is low by at most one, so a single compare and subtract fixes it.
  function automatic byte_t wrap8(input byte_t v, input int unsigned divisor,
                                  input int unsigned recip);
    logic [23:0] prod;
    logic [7:0]  quot;
    logic [8:0]  div9;
    logic [16:0] back;
    logic [8:0]  rem;
    div9 = divisor[8:0];
    prod = {16'h0000, v} * recip[23:0];
    quot = prod[23:16];
    back = quot * div9;
    rem  = {1'b0, v} - back[8:0];
    if (rem >= div9) begin
      rem = rem - div9;
    end
    return rem[7:0];
  endfunction

endpackage

FILE: rtl/fbpa_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_decode: coordinate wrap and store address
// Wraps the column and the row or page and forms the stripe byte address
// and the bit position within the stripe.
// ----------------------------------------------------------------------------
module fbpa_decode import fbpa_pkg::*; (
  input  logic [1:0] operation_i,
  input  logic [7:0] column_x_i,
  input  logic [7:0] row_y_i,
  input  logic [7:0] write_value_i,
  output access_t    access_o
);

  byte_t            col_w;
  byte_t            row_w;
  byte_t            page_col;
  byte_t            page_sel;
  logic [LIN_W-1:0] lin_addr;

  assign col_w    = wrap8(column_x_i, SCREEN_COLUMNS, RECIP_COLUMNS);
  assign row_w    = wrap8(row_y_i, PIXEL_ROWS, RECIP_ROWS);
  assign page_col = wrap8(row_y_i, SCREEN_PAGES, RECIP_PAGES);

  // Pixel ops take the page from the row; column ops take it directly.
  assign page_sel = operation_i[1] ? page_col : {3'b000, row_w[7:3]};

  assign lin_addr = LIN_W'({3'b000, col_w} * LIN_W'(SCREEN_PAGES))
                  + LIN_W'({3'b000, page_sel});

  always_comb begin
    access_o.op      = op_e'(operation_i);
    access_o.addr    = lin_addr[ADDR_W-1:0];
    access_o.bit_sel = row_w[2:0];
    access_o.wdata   = write_value_i;
  end

endmodule

FILE: rtl/fbpa_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_store: frame store with clearing sweep
// Byte-wide memory with one registered read port and one write port.
// After reset it writes zeros to every entry, one per cycle.
// ----------------------------------------------------------------------------
module fbpa_store import fbpa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     rd_en_i,
  input  addr_t    rd_addr_i,
  output byte_t    rd_data_o,
  input  wr_port_t wr_i,
  output logic     clearing_o
);

  byte_t mem [STORE_DEPTH];
  byte_t rd_data_q;
  addr_t clr_cnt_q, clr_cnt_d;
  logic  clearing_q, clearing_d;

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + addr_t'(1);
      if (clr_cnt_q == addr_t'(STORE_DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clearing_q <= clearing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

FILE: rtl/page_framebuffer_pixel_access.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_pixel_access: pixel and column access to a page framebuffer
// A 128x32 monochrome framebuffer stored as 512 vertical 8-pixel stripe bytes,
// with pixel read, pixel write, column read and column write.
// ----------------------------------------------------------------------------
// After reset the block clears its frame store, one byte per cycle, and holds
// busy high while it does so; from then on busy stays low and a word is
// taken at every rising edge where start is high, one word per cycle. A read
// returns its word through the registered read of the frame store, then the
// modify logic and the result register: result_valid_o is high for exactly
// one cycle with read_data_o, and results come out in the order the reads
// went in. Writes return nothing. There is no way to stall the result side,
// so the receiver must take every result on the cycle it is shown. A write
// to the same byte by the word just ahead is forwarded, so back-to-back
// pixel writes to one stripe are safe.
// ----------------------------------------------------------------------------
module page_framebuffer_pixel_access import fbpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation_i,
  input  logic [7:0] column_x_i,
  input  logic [7:0] row_y_i,
  input  logic [7:0] write_value_i,
  output logic       result_valid_o,
  output logic [7:0] read_data_o
);

  access_t  acc_in;
  access_t  acc_q;
  logic     valid_q;
  logic     accept;
  logic     clearing;
  byte_t    rd_data;
  wr_port_t wr_port;

  // Forwarding of the byte written by the word one stage ahead.
  logic     fwd_hit_q, fwd_hit_d;
  byte_t    fwd_data_q;

  byte_t    cur_byte;
  byte_t    bit_mask;
  byte_t    new_byte;
  logic     s1_write;

  logic     res_valid_q, res_valid_d;
  byte_t    res_data_q, res_data_d;

  assign busy   = clearing;
  assign accept = start && !busy;

  fbpa_decode u_decode (
    .operation_i   (operation_i),
    .column_x_i    (column_x_i),
    .row_y_i       (row_y_i),
    .write_value_i (write_value_i),
    .access_o      (acc_in)
  );

  fbpa_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (acc_in.addr),
    .rd_data_o  (rd_data),
    .wr_i       (wr_port),
    .clearing_o (clearing)
  );

  // Stage one: the word sits here while the store read data arrives.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q <= acc_in;
    end
  end

  assign s1_write = valid_q && ((acc_q.op == OP_WR_PIXEL) || (acc_q.op == OP_WR_COLUMN));

  // The read of the next word happens on the same edge as this word's write,
  // so the store returns the old byte; take the fresh byte instead.
  assign fwd_hit_d = accept && s1_write && (acc_in.addr == acc_q.addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= fwd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= new_byte;
  end

  assign cur_byte = fwd_hit_q ? fwd_data_q : rd_data;
  assign bit_mask = byte_t'(1) << acc_q.bit_sel;

  always_comb begin
    new_byte    = cur_byte;
    res_valid_d = 1'b0;
    res_data_d  = cur_byte;
    case (acc_q.op)
      OP_WR_PIXEL: begin
        new_byte = acc_q.wdata[0] ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);
      end
      OP_RD_PIXEL: begin
        res_valid_d = valid_q;
        res_data_d  = {7'b0000000, |(cur_byte & bit_mask)};
      end
      OP_WR_COLUMN: begin
        new_byte = acc_q.wdata;
      end
      OP_RD_COLUMN: begin
        res_valid_d = valid_q;
      end
      default: begin
        new_byte = cur_byte;
      end
    endcase
  end

  always_comb begin
    wr_port.en   = s1_write;
    wr_port.addr = acc_q.addr;
    wr_port.data = new_byte;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_data_q <= res_data_d;
  end

  assign result_valid_o = res_valid_q;
  assign read_data_o    = res_data_q;

endmodule

FILE: rtl/fbpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_checker: port-level checks of the page framebuffer
// Watches the command and result ports for latency, pixel read and busy rules.
// ----------------------------------------------------------------------------
module fbpa_checker import fbpa_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] operation_i,
  input logic       result_valid_o,
  input logic [7:0] read_data_o
);

  logic take_read;
  logic take_pixel_read;

  assign take_read       = start && !busy && operation_i[0];
  assign take_pixel_read = start && !busy && (operation_i == OP_RD_PIXEL);

  // Every result belongs to a read word taken earlier.
  a_result_has_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(take_read, 2))
    else $error("result without a read two cycles earlier");

  // Every read word gives its result.
  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(take_read, 2) |-> result_valid_o)
    else $error("read word lost its result");

  // A pixel read returns only bit 0.
  a_pixel_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(take_pixel_read, 2) |-> (read_data_o[7:1] == 7'd0))
    else $error("pixel read result has upper bits set");

  // Busy only covers the clearing sweep after reset and never comes back.
  a_busy_no_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$rose(busy))
    else $error("busy rose after the clearing sweep");

endmodule

bind page_framebuffer_pixel_access fbpa_checker u_fbpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .operation_i    (operation_i),
  .result_valid_o (result_valid_o),
  .read_data_o    (read_data_o)
);
